// File: src/wufl_pkg.sv
// Shared constants, types and controller codes for the union-find engine.
package wufl_pkg;

	localparam int NODES  = 1024;
	localparam int NODE_W = 10;
	localparam int SIZE_W = 11;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [SIZE_W-1:0] size_t;

	// Per-root record: member count and greatest member.
	typedef struct packed {
		size_t size;
		node_t largest;
	} info_t;

	localparam int INFO_W = $bits(info_t);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_CHK,
		ST_COMP,
		ST_END,
		ST_INFO_A,
		ST_INFO_B,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic clr;        // write reset values at the sweep address, advance
		logic load;       // capture the input item
		logic phase_b;    // walk starts from node_b
		logic issue;      // read the start node's link, point the walker there
		logic walk;       // follow the link just read
		logic root_take;  // walker sits on the root
		logic comp_wr;    // repoint the walked node at the root
		logic take_ra;    // keep the root of node_a
		logic info_rd_b;  // read root record of node_b (else node_a)
		logic info_cap;   // capture node_a's root record
		logic merge;      // unite if asked, load the result
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic link_eq_cur;
		logic link_eq_root;
		logic start_eq_cur;
	} status_t;

endpackage

// File: src/wufl_ram.sv
// Generic single-write, single-read memory with registered read data.
module wufl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/wufl_ctrl.sv
// Controller state machine sequencing the root walks, compression and merge.
module wufl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  wufl_pkg::status_t status,
	output wufl_pkg::cmd_t    cmd
);

	wufl_pkg::state_t state_q, state_nx;
	logic ph_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == wufl_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			wufl_pkg::ST_CLEAR: begin
				if (status.clr_last) state_nx = wufl_pkg::ST_IDLE;
			end
			wufl_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = wufl_pkg::ST_START;
			end
			wufl_pkg::ST_START: state_nx = wufl_pkg::ST_CHK;
			wufl_pkg::ST_CHK: begin
				if (status.link_eq_cur) begin
					state_nx = status.start_eq_cur ? wufl_pkg::ST_END : wufl_pkg::ST_COMP;
				end
			end
			wufl_pkg::ST_COMP: begin
				if (status.link_eq_root) state_nx = wufl_pkg::ST_END;
			end
			wufl_pkg::ST_END: begin
				state_nx = ph_q ? wufl_pkg::ST_INFO_A : wufl_pkg::ST_START;
			end
			wufl_pkg::ST_INFO_A: state_nx = wufl_pkg::ST_INFO_B;
			wufl_pkg::ST_INFO_B: state_nx = wufl_pkg::ST_MERGE;
			wufl_pkg::ST_MERGE: begin
				if (out_free) state_nx = wufl_pkg::ST_IDLE;
			end
			default: state_nx = wufl_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.phase_b = ph_q;
		case (state_q)
			wufl_pkg::ST_CLEAR: cmd.clr = 1'b1;
			wufl_pkg::ST_IDLE: cmd.load = s_tvalid;
			wufl_pkg::ST_START: cmd.issue = 1'b1;
			wufl_pkg::ST_CHK: begin
				if (status.link_eq_cur) begin
					cmd.root_take = 1'b1;
					cmd.issue     = !status.start_eq_cur;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			wufl_pkg::ST_COMP: begin
				cmd.comp_wr = 1'b1;
				cmd.walk    = !status.link_eq_root;
			end
			wufl_pkg::ST_END: cmd.take_ra = !ph_q;
			wufl_pkg::ST_INFO_A: cmd.info_rd_b = 1'b0;
			wufl_pkg::ST_INFO_B: begin
				cmd.info_rd_b = 1'b1;
				cmd.info_cap  = 1'b1;
			end
			wufl_pkg::ST_MERGE: begin
				// hold the read address so node_b's record stays on the port
				cmd.info_rd_b = 1'b1;
				cmd.merge     = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wufl_pkg::ST_CLEAR;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				ph_q <= 1'b0;
			end else if (state_q == wufl_pkg::ST_END) begin
				ph_q <= 1'b1;
			end
			if (cmd.merge) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/wufl_dpath.sv
// Datapath: link and root-record memories, walker, merge arithmetic, result register.
module wufl_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_func,
	input  wufl_pkg::node_t       in_node_a,
	input  wufl_pkg::node_t       in_node_b,
	input  wufl_pkg::cmd_t        cmd,
	output wufl_pkg::status_t     status,
	output logic                  already_joined,
	output wufl_pkg::size_t       set_size_a,
	output wufl_pkg::node_t       largest_in_a,
	output wufl_pkg::size_t       set_count
);

	logic            func_q;
	wufl_pkg::node_t a_q, b_q, cur_q, root_q, ra_q, clr_q;
	wufl_pkg::size_t sets_q;
	wufl_pkg::info_t info_a_q;

	logic            joined_q;
	wufl_pkg::size_t size_q, count_q;
	wufl_pkg::node_t large_q;

	wufl_pkg::node_t p_raddr, p_waddr, p_wdata, p_rdata, start;
	logic            p_we;
	wufl_pkg::node_t i_raddr, i_waddr;
	wufl_pkg::info_t i_wdata, i_rdata, clr_info, new_info;
	logic            i_we;

	logic            joined, a_small, do_union;
	wufl_pkg::node_t big, small_root;

	assign start = cmd.phase_b ? b_q : a_q;

	always_comb begin
		p_raddr = cur_q;
		if (cmd.issue) begin
			p_raddr = start;
		end else if (cmd.walk) begin
			p_raddr = p_rdata;
		end
	end

	assign status.clr_last     = (clr_q == wufl_pkg::node_t'(wufl_pkg::NODES - 1));
	assign status.link_eq_cur  = (p_rdata == cur_q);
	assign status.link_eq_root = (p_rdata == root_q);
	assign status.start_eq_cur = (start == cur_q);

	// Merge: smaller tree goes under the larger, ties keep node_a's root.
	assign joined     = (ra_q == root_q);
	assign a_small    = (info_a_q.size < i_rdata.size);
	assign big        = a_small ? root_q : ra_q;
	assign small_root = a_small ? ra_q : root_q;
	assign do_union   = func_q && !joined;

	always_comb begin
		new_info.size    = info_a_q.size + i_rdata.size;
		new_info.largest = (info_a_q.largest > i_rdata.largest) ? info_a_q.largest
			: i_rdata.largest;
	end

	always_comb begin
		clr_info.size    = wufl_pkg::size_t'(1);
		clr_info.largest = clr_q;
	end

	always_comb begin
		p_we    = cmd.clr || cmd.comp_wr || (cmd.merge && do_union);
		p_waddr = clr_q;
		p_wdata = clr_q;
		if (cmd.comp_wr) begin
			p_waddr = cur_q;
			p_wdata = root_q;
		end else if (cmd.merge) begin
			p_waddr = small_root;
			p_wdata = big;
		end
	end

	assign i_raddr = cmd.info_rd_b ? root_q : ra_q;
	assign i_we    = cmd.clr || (cmd.merge && do_union);
	assign i_waddr = cmd.clr ? clr_q : big;
	assign i_wdata = cmd.clr ? clr_info : new_info;

	wufl_ram #(
		.WIDTH (wufl_pkg::NODE_W),
		.DEPTH (wufl_pkg::NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	wufl_ram #(
		.WIDTH (wufl_pkg::INFO_W),
		.DEPTH (wufl_pkg::NODES)
	) u_info_ram (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_waddr),
		.wdata (i_wdata),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			sets_q <= wufl_pkg::size_t'(wufl_pkg::NODES);
		end else begin
			if (cmd.clr) clr_q <= clr_q + wufl_pkg::node_t'(1);
			if (cmd.merge && do_union && sets_q != '0) begin
				sets_q <= sets_q - wufl_pkg::size_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			a_q    <= in_node_a;
			b_q    <= in_node_b;
		end
		if (cmd.issue) begin
			cur_q <= start;
		end else if (cmd.walk) begin
			cur_q <= p_rdata;
		end
		if (cmd.root_take) root_q <= cur_q;
		if (cmd.take_ra) ra_q <= root_q;
		if (cmd.info_cap) info_a_q <= i_rdata;
		if (cmd.merge) begin
			joined_q <= joined;
			size_q   <= do_union ? new_info.size : info_a_q.size;
			large_q  <= do_union ? new_info.largest : info_a_q.largest;
			count_q  <= (do_union && sets_q != '0) ? sets_q - wufl_pkg::size_t'(1) : sets_q;
		end
	end

	assign already_joined = joined_q;
	assign set_size_a     = size_q;
	assign largest_in_a   = large_q;
	assign set_count      = count_q;

endmodule

// File: src/weighted_union_find_largest.sv
// Top level of the disjoint-set engine (weighted union, path compression).
//
//  channel  direction  tdata (low bit up)                              tuser
//  s_*      in         node_a[9:0], node_b[19:10], zero pad to 24     func
//  m_*      out        already_joined[0], set_size_a[11:1],            -
//                      largest_in_a[21:12], set_count[32:22], pad to 40
//
// An item walks from each of node_a and node_b to its root and then back along
// the path for compression: the link memory has one read port, so the root
// walk and the compression walk each read one link a cycle. s_tready rises
// when the result is loaded. After reset a clearing pass writes all 1024
// entries of the memories; s_tready stays low until it ends. A result waiting
// on m_tready holds the merge step; one item is in work at a time.
module weighted_union_find_largest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // node_a, node_b, pad
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // already_joined, set_size_a, largest_in_a, set_count, pad
);

	wufl_pkg::cmd_t    cmd;
	wufl_pkg::status_t status;
	logic              already_joined;
	wufl_pkg::size_t   set_size_a, set_count;
	wufl_pkg::node_t   largest_in_a;

	wufl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wufl_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_func        (s_tuser),
		.in_node_a      (s_tdata[9:0]),
		.in_node_b      (s_tdata[19:10]),
		.cmd            (cmd),
		.status         (status),
		.already_joined (already_joined),
		.set_size_a     (set_size_a),
		.largest_in_a   (largest_in_a),
		.set_count      (set_count)
	);

	assign m_tdata = {7'b0, set_count, largest_in_a, set_size_a, already_joined};

endmodule

// File: test/tb_weighted_union_find_largest.sv
// Self-checking testbench for the weighted union-find engine with path compression.
module tb_weighted_union_find_largest;

	typedef enum bit {OP_QUERY, OP_UNITE} op_t;

	typedef struct packed {
		logic            joined;
		wufl_pkg::size_t size_a;
		wufl_pkg::node_t largest;
		wufl_pkg::size_t count;
	} uf_result_t;

	typedef struct packed {
		op_t             op;
		wufl_pkg::node_t a;
		wufl_pkg::node_t b;
		bit              typed;
		uf_result_t      res;
	} plan_row_t;

	localparam int RANDOM_ITEMS = 1050;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // node_a, node_b, pad
	logic        s_tuser  = 1'b0; // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // already_joined, set_size_a, largest_in_a, set_count, pad

	// Mirror of the engine's forest.
	wufl_pkg::node_t link_of    [wufl_pkg::NODES];
	wufl_pkg::size_t members_of [wufl_pkg::NODES];
	wufl_pkg::node_t top_member [wufl_pkg::NODES];
	int              sets_left;

	uf_result_t pending_results [$];
	int         n_fail     = 0;
	int         burst_left = 0;
	int         ready_mode = 0;
	int         mode_left  = 0;

	// Directed rows: typed results only where they follow from the fresh state.
	plan_row_t plan [22] = '{
		'{OP_QUERY, 10'd0,    10'd0,    1'b1, '{1'b1, 11'd1, 10'd0,    11'd1024}},
		'{OP_QUERY, 10'd1023, 10'd1023, 1'b1, '{1'b1, 11'd1, 10'd1023, 11'd1024}},
		'{OP_QUERY, 10'd0,    10'd1023, 1'b1, '{1'b0, 11'd1, 10'd0,    11'd1024}},
		'{OP_UNITE, 10'd0,    10'd1023, 1'b1, '{1'b0, 11'd2, 10'd1023, 11'd1023}},
		'{OP_UNITE, 10'd1023, 10'd0,    1'b1, '{1'b1, 11'd2, 10'd1023, 11'd1023}},
		'{OP_QUERY, 10'd1023, 10'd0,    1'b1, '{1'b1, 11'd2, 10'd1023, 11'd1023}},
		'{OP_UNITE, 10'd682,  10'd341,  1'b0, '0},
		'{OP_UNITE, 10'd341,  10'd0,    1'b0, '0},
		'{OP_UNITE, 10'd5,    10'd5,    1'b1, '{1'b1, 11'd1, 10'd5,    11'd1021}},
		'{OP_UNITE, 10'd6,    10'd5,    1'b0, '0},
		'{OP_UNITE, 10'd7,    10'd5,    1'b0, '0},
		'{OP_UNITE, 10'd4,    10'd7,    1'b0, '0},
		'{OP_UNITE, 10'd8,    10'd9,    1'b0, '0},
		'{OP_UNITE, 10'd10,   10'd11,   1'b0, '0},
		'{OP_UNITE, 10'd8,    10'd10,   1'b0, '0},
		'{OP_UNITE, 10'd4,    10'd8,    1'b0, '0},
		'{OP_QUERY, 10'd11,   10'd4,    1'b0, '0},
		'{OP_UNITE, 10'd1,    10'd1000, 1'b0, '0},
		'{OP_UNITE, 10'd1000, 10'd4,    1'b0, '0},
		'{OP_QUERY, 10'd512,  10'd511,  1'b0, '0},
		'{OP_UNITE, 10'd0,    10'd11,   1'b0, '0},
		'{OP_QUERY, 10'd9,    10'd682,  1'b0, '0}
	};

	weighted_union_find_largest u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Walk to the root, then point every node on the path straight at it.
	function automatic wufl_pkg::node_t root_of(wufl_pkg::node_t x);
		wufl_pkg::node_t r;
		wufl_pkg::node_t nx;
		r = x;
		while (link_of[r] != r)
			r = link_of[r];
		while (x != r) begin
			nx = link_of[x];
			link_of[x] = r;
			x = nx;
		end
		return r;
	endfunction

	function automatic uf_result_t apply_union_find(op_t op, wufl_pkg::node_t a,
		wufl_pkg::node_t b);
		wufl_pkg::node_t ra;
		wufl_pkg::node_t rb;
		wufl_pkg::node_t big;
		wufl_pkg::node_t sml;
		uf_result_t      res;
		ra = root_of(a);
		rb = root_of(b);
		res.joined = (ra == rb);
		if (op == OP_UNITE && ra != rb) begin
			big = ra;
			sml = rb;
			// ties keep node_a's root on top
			if (members_of[ra] < members_of[rb]) begin
				big = rb;
				sml = ra;
			end
			link_of[sml] = big;
			members_of[big] = members_of[big] + members_of[sml];
			if (top_member[sml] > top_member[big])
				top_member[big] = top_member[sml];
			if (sets_left > 0)
				sets_left--;
		end
		ra = root_of(a);
		res.size_a  = members_of[ra];
		res.largest = top_member[ra];
		res.count   = wufl_pkg::size_t'(sets_left);
		return res;
	endfunction

	// Dense low indices build deep, well-joined trees; the rest spread over the range.
	function automatic wufl_pkg::node_t pick_node();
		if ($urandom_range(0, 99) < 40)
			return wufl_pkg::node_t'($urandom_range(0, 63));
		return wufl_pkg::node_t'($urandom_range(0, wufl_pkg::NODES - 1));
	endfunction

	task automatic send_item(op_t op, wufl_pkg::node_t a, wufl_pkg::node_t b);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, b, a};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		pending_results.push_back(apply_union_find(op, a, b));
	endtask

	// Receiver: switch between free flow, random stalls and heavy back-pressure.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(4, 80);
		end
		mode_left--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		uf_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding: tdata %h", m_tdata);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.joined) begin
					$error("already_joined: expected %0d, got %0d", want.joined, m_tdata[0]);
					n_fail++;
				end
				if (m_tdata[11:1] !== want.size_a) begin
					$error("set_size_a: expected %0d, got %0d", want.size_a, m_tdata[11:1]);
					n_fail++;
				end
				if (m_tdata[21:12] !== want.largest) begin
					$error("largest_in_a: expected %0d, got %0d", want.largest,
						m_tdata[21:12]);
					n_fail++;
				end
				if (m_tdata[32:22] !== want.count) begin
					$error("set_count: expected %0d, got %0d", want.count, m_tdata[32:22]);
					n_fail++;
				end
			end
		end
	end

	initial begin : stimulus
		op_t             op;
		wufl_pkg::node_t a;
		wufl_pkg::node_t b;
		for (int i = 0; i < wufl_pkg::NODES; i++) begin
			link_of[i]    = wufl_pkg::node_t'(i);
			members_of[i] = wufl_pkg::size_t'(1);
			top_member[i] = wufl_pkg::node_t'(i);
		end
		sets_left = wufl_pkg::NODES;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_item(plan[i].op, plan[i].a, plan[i].b);
			// replace the prediction with the hand-worked result
			if (plan[i].typed)
				pending_results[pending_results.size() - 1] = plan[i].res;
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op = ($urandom_range(0, 99) < 70) ? OP_UNITE : OP_QUERY;
			a  = pick_node();
			b  = ($urandom_range(0, 19) == 0) ? a : pick_node();
			send_item(op, a, b);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_fail == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
